FILE: rtl/pmar_pkg.sv
// Package for the paged MMU with aging replacement.
// Holds sizes, status codes and the controller/datapath command and status structs.
package pmar_pkg;
  localparam int PAGE_BYTES_D    = 16;
  localparam int OUTER_ENTRIES_D = 4;
  localparam int INNER_ENTRIES_D = 8;
  localparam int FRAMES_D        = 16;
  localparam int PROCESSES_D     = 4;

  localparam logic [7:0] AGE_TOP = 8'h80;
  localparam logic [7:0] AGE_MAX = 8'hFF;
  localparam logic [7:0] PERIOD_RESET = 8'd10;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BOUNDS   = 3'd1;
  localparam logic [2:0] ST_PROCESS  = 3'd2;
  localparam logic [2:0] ST_READ_DN  = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd6;

  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  typedef struct packed {
    logic load;        // latch request, decode
    logic frame_clr;   // clear frame scan index
    logic frame_step;  // test one frame
    logic age_clr;     // clear page scan index
    logic age_step;    // test one page for victim
    logic commit;      // apply fault / access updates, build result
    logic tick;        // bump tick counter
    logic shift_step;  // age one page
    logic emit;        // drive result strobe
  } pmar_cmd_t;

  typedef struct packed {
    logic is_load_op;
    logic oob;
    logic wrong_pid;
    logic present;
    logic frame_done;   // scan ended
    logic frame_found;
    logic age_done;
    logic age_due;      // tick reached period
    logic shift_done;
  } pmar_sts_t;
endpackage

FILE: rtl/pmar_ctrl.sv
// Sequencer for the paged MMU: steps decode, frame scan, victim scan, commit, aging.
// Depends on pmar_pkg.
module pmar_ctrl import pmar_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  pmar_sts_t sts,
  output pmar_cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_FSCAN, S_ASCAN, S_COMMIT, S_TICK, S_SHIFT, S_EMIT
  } state_t;
  state_t state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.frame_clr = 1'b1;
        if (sts.is_load_op) state_nxt = S_EMIT;
        else if (sts.oob || sts.wrong_pid || sts.present) state_nxt = S_COMMIT;
        else state_nxt = S_FSCAN;
      end
      S_FSCAN: begin
        cmd.frame_step = 1'b1;
        cmd.age_clr = 1'b1;
        if (sts.frame_found) state_nxt = S_COMMIT;
        else if (sts.frame_done) state_nxt = S_ASCAN;
      end
      S_ASCAN: begin
        cmd.age_step = 1'b1;
        if (sts.age_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_TICK;
      end
      S_TICK: begin
        cmd.tick = 1'b1;
        cmd.age_clr = 1'b1;
        state_nxt = sts.age_due ? S_SHIFT : S_EMIT;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
endmodule

FILE: rtl/pmar_dp.sv
// Datapath for the paged MMU: page table, frame map, scan indexes, result register.
// Depends on pmar_pkg; driven by pmar_ctrl commands.
module pmar_dp import pmar_pkg::*; #(
  parameter int PAGE_BYTES    = PAGE_BYTES_D,
  parameter int OUTER_ENTRIES = OUTER_ENTRIES_D,
  parameter int INNER_ENTRIES = INNER_ENTRIES_D,
  parameter int FRAMES        = FRAMES_D
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pmar_cmd_t  cmd,
  output pmar_sts_t  sts,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_op,
  input  logic [9:0] in_virtual_address,
  input  logic [1:0] in_process_id,
  input  logic [1:0] in_access_kind,
  input  logic [4:0] in_target_page,
  input  logic [2:0] in_protection_bits,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [7:0] out_physical_address,
  output logic       out_page_fault,
  output logic [3:0] out_fill_frame,
  output logic       out_evicted,
  output logic [4:0] out_evicted_page,
  output logic       out_write_back
);
  localparam int PAGES = OUTER_ENTRIES * INNER_ENTRIES;
  localparam int VIRT  = PAGES * PAGE_BYTES;
  localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OW = $clog2(PAGE_BYTES);

  logic [PAGES-1:0] present_r, dirty_r, ref_r;
  logic [7:0]       age_r   [PAGES];
  logic [FW-1:0]    frame_r [PAGES];
  logic [1:0]       owner_r [PAGES];
  logic [2:0]       rights_r[PAGES];
  logic [FRAMES-1:0] in_use_r;
  logic [7:0] tick_r, period_r;

  logic       op_r, oob_r;
  logic [9:0] va_r;
  logic [1:0] pid_r, kind_r;

  logic [FW:0] fidx_r;
  logic [PW:0] pidx_r;
  logic [FW-1:0] fill_r;
  logic        fault_r, have_r;
  logic [8:0]  best_r;
  logic [PW-1:0] victim_r;

  logic [2:0] status_r;
  logic [7:0] paddr_r;
  logic       evict_r, wb_r, valid_r;
  logic [4:0] vpage_r;
  logic [7:0] tick_inc;

  logic [PW-1:0] page;
  logic [OW-1:0] off;
  logic [PW-1:0] pscan;
  logic [FW-1:0] fscan;
  logic [FW-1:0] use_frame;
  logic [2:0] rights;

  assign page  = PW'(va_r / PAGE_BYTES);
  assign off   = OW'(va_r % PAGE_BYTES);
  assign pscan = pidx_r[PW-1:0];
  assign fscan = fidx_r[FW-1:0];
  assign tick_inc = tick_r + 8'd1;
  assign rights = rights_r[page];
  assign use_frame = (fault_r ? fill_r : frame_r[page]);

  always_comb begin
    sts.is_load_op  = op_r;
    sts.oob         = oob_r;
    sts.wrong_pid   = owner_r[page] != pid_r;
    sts.present     = present_r[page];
    sts.frame_done  = (fidx_r == (FW+1)'(FRAMES - 1)) || (fidx_r >= (FW+1)'(FRAMES));
    sts.frame_found = !in_use_r[fscan];
    sts.age_done    = (pidx_r == (PW+1)'(PAGES - 1));
    sts.age_due     = !(tick_inc < period_r);
    sts.shift_done  = (pidx_r == (PW+1)'(PAGES - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      present_r <= '0;
      dirty_r   <= '0;
      ref_r     <= '0;
      in_use_r  <= '0;
      tick_r    <= '0;
      period_r  <= PERIOD_RESET;
      for (int i = 0; i < PAGES; i++) begin
        age_r[i]    <= '0;
        frame_r[i]  <= '0;
        owner_r[i]  <= '0;
        rights_r[i] <= '0;
      end
    end else begin
      valid_r <= cmd.emit;
      if (cfg_we) period_r <= cfg_wdata;
      if (cmd.load) begin
        op_r <= in_op;
        va_r <= in_virtual_address;
        oob_r <= (32'(in_virtual_address) >= VIRT);
        pid_r <= in_process_id;
        kind_r <= in_access_kind;
        status_r <= ST_OK;
        paddr_r <= '0;
        fault_r <= 1'b0;
        fill_r <= '0;
        evict_r <= 1'b0;
        vpage_r <= '0;
        wb_r <= 1'b0;
        if (in_op && (32'(in_target_page) < PAGES)) begin
          owner_r[PW'(in_target_page)]  <= in_process_id;
          rights_r[PW'(in_target_page)] <= in_protection_bits;
        end
      end
      if (cmd.frame_clr) begin
        fidx_r <= '0;
      end
      if (cmd.frame_step) begin
        fault_r <= 1'b1;
        if (!in_use_r[fscan]) fill_r <= fscan;
        fidx_r <= fidx_r + 1'b1;
      end
      if (cmd.age_clr) begin
        pidx_r <= '0;
        best_r <= 9'h100;
        have_r <= 1'b0;
        victim_r <= '0;
      end
      if (cmd.age_step) begin
        if (present_r[pscan] && ({1'b0, age_r[pscan]} < best_r)) begin
          best_r <= {1'b0, age_r[pscan]};
          victim_r <= pscan;
          have_r <= 1'b1;
          fill_r <= frame_r[pscan];
        end
        pidx_r <= pidx_r + 1'b1;
      end
      if (cmd.commit) begin
        if (oob_r) status_r <= ST_BOUNDS;
        else if (owner_r[page] != pid_r) status_r <= ST_PROCESS;
        else begin
          if (fault_r) begin
            if (have_r) begin
              evict_r <= 1'b1;
              vpage_r <= 5'(victim_r);
              wb_r <= dirty_r[victim_r];
              present_r[victim_r] <= 1'b0;
              dirty_r[victim_r] <= 1'b0;
              age_r[victim_r] <= '0;
              ref_r[victim_r] <= 1'b0;
            end
            in_use_r[fill_r] <= 1'b1;
            frame_r[page] <= fill_r;
            present_r[page] <= 1'b1;
            age_r[page] <= '0;
          end
          paddr_r <= 8'((32'(use_frame) * PAGE_BYTES) + 32'(off));
          dirty_r[page] <= ((kind_r == KIND_WRITE) && rights[KIND_WRITE]) ? 1'b1 :
                           (fault_r ? 1'b0 : dirty_r[page]);
          ref_r[page] <= (kind_r != KIND_INVALID) || (!fault_r && ref_r[page]);
          if (kind_r == KIND_INVALID) status_r <= ST_INVALID;
          else if (!rights[kind_r]) status_r <= ST_READ_DN + 3'(kind_r);
        end
      end
      if (cmd.tick) begin
        tick_r <= (tick_inc < period_r) ? tick_inc : 8'd0;
      end
      if (cmd.shift_step) begin
        age_r[pscan] <= ref_r[pscan] ? ((age_r[pscan] >> 1) | AGE_TOP) : (age_r[pscan] >> 1);
        ref_r[pscan] <= 1'b0;
        pidx_r <= pidx_r + 1'b1;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_status = status_r;
  assign out_physical_address = paddr_r;
  assign out_page_fault = fault_r;
  assign out_fill_frame = 4'(fill_r);
  assign out_evicted = evict_r;
  assign out_evicted_page = vpage_r;
  assign out_write_back = wb_r;
endmodule

FILE: rtl/paged_mmu_aging_replacement.sv
// Top level of the paged MMU with aging page replacement.
// Joins pmar_ctrl and pmar_dp; depends on pmar_pkg.
//
// Usage: raise start with the request fields; the request is taken at an edge
// where start is high and busy is low. busy stays high until the result beat.
// out_valid marks the result beat for exactly one cycle; the receiver cannot
// stall and must take it then.
// Sequence: op 1 passes decode and emit only. An access passes decode,
// commit, tick and emit on a hit; on a fault a frame scan tests one frame
// at a time (up to FRAMES), and when no frame is free a victim search tests
// every page (PAGES); when the aging period expires, an aging walk over all
// pages follows the tick. The frame scan and page walks set the access time.
// One request is in flight at a time.
// cfg_we writes the aging period; write only while busy is low.
// Reset clears the page table, the frame map and the tick counter and
// loads an aging period of 10.
module paged_mmu_aging_replacement import pmar_pkg::*; #(
  parameter int PAGE_BYTES    = PAGE_BYTES_D,
  parameter int OUTER_ENTRIES = OUTER_ENTRIES_D,
  parameter int INNER_ENTRIES = INNER_ENTRIES_D,
  parameter int FRAMES        = FRAMES_D
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_op,
  input  logic [9:0] in_virtual_address,
  input  logic [1:0] in_process_id,
  input  logic [1:0] in_access_kind,
  input  logic [4:0] in_target_page,
  input  logic [2:0] in_protection_bits,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [7:0] out_physical_address,
  output logic       out_page_fault,
  output logic [3:0] out_fill_frame,
  output logic       out_evicted,
  output logic [4:0] out_evicted_page,
  output logic       out_write_back
);
  pmar_cmd_t cmd;
  pmar_sts_t sts;

  pmar_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  pmar_dp #(
    .PAGE_BYTES(PAGE_BYTES), .OUTER_ENTRIES(OUTER_ENTRIES),
    .INNER_ENTRIES(INNER_ENTRIES), .FRAMES(FRAMES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_op(in_op), .in_virtual_address(in_virtual_address),
    .in_process_id(in_process_id), .in_access_kind(in_access_kind),
    .in_target_page(in_target_page), .in_protection_bits(in_protection_bits),
    .out_valid(out_valid), .out_status(out_status),
    .out_physical_address(out_physical_address), .out_page_fault(out_page_fault),
    .out_fill_frame(out_fill_frame), .out_evicted(out_evicted),
    .out_evicted_page(out_evicted_page), .out_write_back(out_write_back)
  );

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result beat while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");
  a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_page_fault) else $error("evict without fault");
  a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_back |-> out_evicted) else $error("write-back without evict");
endmodule
